FILE: hw/rtl/spab_pkg.sv
// ----------------------------------------------------------------------------
// spab_pkg
// Types and bitboard helper functions for the sliding piece attack generator.
// ----------------------------------------------------------------------------
package spab_pkg;

   localparam int BOARD_BITS = 64;
   localparam int SQ_BITS    = 6;

   // Flipping the rank bits of a square mirrors it across the board's middle.
   localparam logic [SQ_BITS-1:0] SQ_RANK_FLIP = 6'd56;

   // Action codes.
   localparam logic ACTION_BISHOP = 1'b0;
   localparam logic ACTION_ROOK   = 1'b1;

   typedef logic [BOARD_BITS-1:0] board_type;
   typedef logic [SQ_BITS-1:0]    square_type;

   typedef struct packed {
      logic       action;
      board_type  occupancy;
      square_type square;
   } spab_req_type;

   // Reverses the byte order, which reverses the ranks of a bitboard.
   function automatic board_type byte_swap(board_type x);
      board_type y;
      y = '0;
      for (int i = 0; i < 8; i++) begin
         y[8*(7-i) +: 8] = x[8*i +: 8];
      end
      return y;
   endfunction

   // Whole file through the square, without the square itself.
   function automatic board_type file_mask(square_type sq);
      board_type m;
      m = '0;
      for (int i = 0; i < BOARD_BITS; i++) begin
         m[i] = ((i % 8) == int'(sq[2:0])) && (i != int'(sq));
      end
      return m;
   endfunction

   // Diagonal (rank minus file constant) through the square, without it.
   function automatic board_type diag_mask(square_type sq);
      board_type m;
      m = '0;
      for (int i = 0; i < BOARD_BITS; i++) begin
         m[i] = (((i / 8) - (i % 8)) == (int'(sq[5:3]) - int'(sq[2:0])))
                && (i != int'(sq));
      end
      return m;
   endfunction

   // Antidiagonal (rank plus file constant) through the square, without it.
   function automatic board_type antidiag_mask(square_type sq);
      board_type m;
      m = '0;
      for (int i = 0; i < BOARD_BITS; i++) begin
         m[i] = (((i / 8) + (i % 8)) == (int'(sq[5:3]) + int'(sq[2:0])))
                && (i != int'(sq));
      end
      return m;
   endfunction

   // Attacks along one rank; the edge files never block.
   function automatic logic [7:0] rank_row(logic [2:0] file, logic [7:0] occ_row);
      logic [7:0] blockers;
      logic [7:0] row;
      logic       open_up;
      logic       open_dn;
      blockers = occ_row & 8'h7E;
      row      = '0;
      open_up  = 1'b1;
      open_dn  = 1'b1;
      for (int d = 0; d < 8; d++) begin
         if (d > int'(file)) begin
            if (open_up) row[d] = 1'b1;
            if (blockers[d]) open_up = 1'b0;
         end
      end
      for (int d = 7; d >= 0; d--) begin
         if (d < int'(file)) begin
            if (open_dn) row[d] = 1'b1;
            if (blockers[d]) open_dn = 1'b0;
         end
      end
      return row;
   endfunction

endpackage

FILE: hw/rtl/spab_line.sv
// ----------------------------------------------------------------------------
// spab_line
// Attacks along one line through the square by the subtraction trick, done
// once on the board and once on the rank-reversed board.
// ----------------------------------------------------------------------------
module spab_line
   import spab_pkg::*;
(
   input  board_type  occupancy,
   input  square_type square,
   input  board_type  line_mask,
   output board_type  attacks
);

   board_type masked;
   board_type fwd;
   board_type rev;

   assign masked = occupancy & line_mask;
   assign fwd    = masked - (board_type'(1) << square);
   assign rev    = byte_swap(byte_swap(masked) - (board_type'(1) << (square ^ SQ_RANK_FLIP)));

   assign attacks = (fwd ^ rev) & line_mask;

endmodule

FILE: hw/rtl/spab_rank.sv
// ----------------------------------------------------------------------------
// spab_rank
// Attacks along the square's rank from the inner occupancy bits of that rank.
// ----------------------------------------------------------------------------
module spab_rank
   import spab_pkg::*;
(
   input  board_type  occupancy,
   input  square_type square,
   output board_type  attacks
);

   logic [7:0] occ_row;
   logic [7:0] row;

   assign occ_row = occupancy[{square[5:3], 3'b000} +: 8];
   assign row     = rank_row(square[2:0], occ_row);
   assign attacks = board_type'(row) << {square[5:3], 3'b000};

endmodule

FILE: hw/rtl/sliding_piece_attack_bitboard.sv
// An accepted request goes to the request register, its result to the result register.
// Throughput: one transaction per cycle while the output is not stalled; the line
// subtractions and the rank lookup sit in one combinational stage between those registers.
// The request stage refills while a finished result waits on a stalled output.
// Reset (synchronous, active high) empties both stages; nothing else is kept.
// ----------------------------------------------------------------------------
// sliding_piece_attack_bitboard
// Bishop and rook attack sets for one square and a board occupancy.
// ----------------------------------------------------------------------------
module sliding_piece_attack_bitboard
   import spab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_occupancy,
   input  logic [5:0]  req_square,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_attacks
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   spab_req_type s1_req_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   board_type    out_attacks_ff;
   board_type    out_attacks_in;

   logic         s1_advance;
   logic         req_fire;
   board_type    mask_a;
   board_type    mask_b;
   board_type    line_a;
   board_type    line_b;
   board_type    rank_att;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   // A rook uses the file line, a bishop the diagonal; the second line is
   // only used by a bishop.
   assign mask_a = (s1_req_ff.action == ACTION_ROOK) ? file_mask(s1_req_ff.square)
                                                     : diag_mask(s1_req_ff.square);
   assign mask_b = antidiag_mask(s1_req_ff.square);

   spab_line u_line_a (
      .occupancy (s1_req_ff.occupancy),
      .square    (s1_req_ff.square),
      .line_mask (mask_a),
      .attacks   (line_a)
   );

   spab_line u_line_b (
      .occupancy (s1_req_ff.occupancy),
      .square    (s1_req_ff.square),
      .line_mask (mask_b),
      .attacks   (line_b)
   );

   spab_rank u_rank (
      .occupancy (s1_req_ff.occupancy),
      .square    (s1_req_ff.square),
      .attacks   (rank_att)
   );

   assign out_attacks_in = (s1_req_ff.action == ACTION_ROOK) ? (rank_att | line_a)
                                                             : (line_a | line_b);

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff.action    <= req_action;
         s1_req_ff.occupancy <= req_occupancy;
         s1_req_ff.square    <= req_square;
      end
      if (s1_advance) begin
         out_attacks_ff <= out_attacks_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_attacks = out_attacks_ff;

endmodule

FILE: hw/rtl/spab_checker.sv
// ----------------------------------------------------------------------------
// spab_checker
// Port-level checks for the attack generator, bound to the top level.
// ----------------------------------------------------------------------------
module spab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_attacks
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_attacks))
      else $error("stalled response changed");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // After an accept, the output holds that transaction or one ahead of it.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("response missing two cycles after accept");

   // Requests are only held off by a stalled output.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

endmodule

bind sliding_piece_attack_bitboard spab_checker u_spab_checker (.*);
